// ===== rtl/srs_pkg.sv =====
// Package for the streaming substring replacer: request and job types, register map.
package srs_pkg;

    localparam int BYTE_W = 8;
    localparam int REG_W = 64;
    localparam int LEN_W = 4;
    localparam int ADDR_W = 5;
    localparam int JOB_BYTES = 8;
    localparam int JOB_QUEUE_DEPTH = 4;

    localparam logic [1:0] REG_PAT_BYTES = 2'd0;
    localparam logic [1:0] REG_PAT_LEN = 2'd1;
    localparam logic [1:0] REG_REP_BYTES = 2'd2;
    localparam logic [1:0] REG_REP_LEN = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic in_last;
    } t_in_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic byte_present;
        logic out_last;
    } t_out_req;

    typedef struct packed {
        logic [REG_W-1:0] pat_bytes;
        logic [LEN_W-1:0] pat_len;
        logic [REG_W-1:0] rep_bytes;
        logic [LEN_W-1:0] rep_len;
    } t_cfg;

    // bytes to emit in order, first in bits 7..0; a zero count with last set is the empty end mark
    typedef struct packed {
        logic [JOB_BYTES*BYTE_W-1:0] data;
        logic [LEN_W-1:0] cnt;
        logic last;
    } t_job;

endpackage

// ===== rtl/substring_replace_stream.sv =====
// Top level of the streaming substring replacer with its register port.
// Replaces every leftmost, non-overlapping occurrence of the pattern in a byte stream. An input
// request is taken each cycle while the job queue has room; the output gives one byte per
// cycle while it is not stalled, so a request that yields a burst of results (a replacement or
// the flush on the last byte) holds the output until all of them are out and back-pressures the
// input once the four-entry job queue fills. The first result of a request passes through the
// job queue, the back end's current-job register and its output register. An empty pattern passes
// bytes through; a last byte that yields nothing gives one empty result with out_last set.
// Writing the pattern or its length drops the bytes held in the window.
module substring_replace_stream #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACEMENT_MAX = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srs_pkg::ADDR_W-1:0]  paddr,
    input  logic [srs_pkg::REG_W-1:0]   pwdata,
    output logic [srs_pkg::REG_W-1:0]   prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  srs_pkg::t_in_req            i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output srs_pkg::t_out_req           o_out_req
);

    srs_pkg::t_cfg  r_cfg;
    srs_pkg::t_job  f_job, q_job;
    logic [1:0]     reg_sel;
    logic           wr, clr, push, pop, q_full, q_nempty;

    assign pready = 1'b1;
    assign reg_sel = paddr[4:3];
    assign wr = psel && penable && pwrite;
    assign clr = wr && ((reg_sel == srs_pkg::REG_PAT_BYTES) || (reg_sel == srs_pkg::REG_PAT_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (reg_sel)
                srs_pkg::REG_PAT_BYTES: r_cfg.pat_bytes <= pwdata;
                srs_pkg::REG_PAT_LEN:   r_cfg.pat_len <= pwdata[srs_pkg::LEN_W-1:0];
                srs_pkg::REG_REP_BYTES: r_cfg.rep_bytes <= pwdata;
                srs_pkg::REG_REP_LEN:   r_cfg.rep_len <= pwdata[srs_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            srs_pkg::REG_PAT_BYTES: prdata = r_cfg.pat_bytes;
            srs_pkg::REG_PAT_LEN:   prdata = srs_pkg::REG_W'(r_cfg.pat_len);
            srs_pkg::REG_REP_BYTES: prdata = r_cfg.rep_bytes;
            srs_pkg::REG_REP_LEN:   prdata = srs_pkg::REG_W'(r_cfg.rep_len);
            default:                prdata = '0;
        endcase
    end

    assign o_in_stall = q_full;

    srs_front #(
        .PATTERN_MAX(PATTERN_MAX),
        .REPLACEMENT_MAX(REPLACEMENT_MAX)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_clr(clr),
        .i_valid(i_in_valid),
        .i_stall(q_full),
        .i_req(i_in_req),
        .o_push(push),
        .o_job(f_job)
    );

    srs_queue #(
        .DEPTH(srs_pkg::JOB_QUEUE_DEPTH)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_job(f_job),
        .i_pop(pop),
        .o_full(q_full),
        .o_nempty(q_nempty),
        .o_job(q_job)
    );

    srs_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_q_nempty(q_nempty),
        .i_q_job(q_job),
        .o_q_pop(pop),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_req(o_out_req)
    );

endmodule

// ===== rtl/srs_front.sv =====
// Front end: holds the match window, classifies each request and builds an emission job.
module srs_front #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACEMENT_MAX = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srs_pkg::t_cfg   i_cfg,
    input  logic            i_clr,
    input  logic            i_valid,
    input  logic            i_stall,
    input  srs_pkg::t_in_req i_req,
    output logic            o_push,
    output srs_pkg::t_job   o_job
);

    localparam int VW = srs_pkg::JOB_BYTES * srs_pkg::BYTE_W;

    logic [srs_pkg::BYTE_W-1:0] r_win [PATTERN_MAX];
    logic [srs_pkg::BYTE_W-1:0] n_win [PATTERN_MAX];
    logic [srs_pkg::BYTE_W-1:0] win_new [PATTERN_MAX];
    logic [srs_pkg::LEN_W-1:0]  r_fill, n_fill;
    logic [srs_pkg::LEN_W-1:0]  plen, rlen, fill0, filled;
    logic [VW-1:0]              wv, shv;
    logic                       accept, complete, hit;

    assign accept = i_valid && !i_stall;
    assign plen = (i_cfg.pat_len > srs_pkg::LEN_W'(PATTERN_MAX)) ?
                  srs_pkg::LEN_W'(PATTERN_MAX) : i_cfg.pat_len;
    assign rlen = (i_cfg.rep_len > srs_pkg::LEN_W'(REPLACEMENT_MAX)) ?
                  srs_pkg::LEN_W'(REPLACEMENT_MAX) : i_cfg.rep_len;
    assign fill0 = (r_fill >= plen) ? '0 : r_fill;
    assign filled = fill0 + 1'b1;
    assign complete = (filled == plen);

    always_comb begin
        wv = '0;
        hit = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_new[i] = (srs_pkg::LEN_W'(i) == fill0) ? i_req.in_byte : r_win[i];
            wv[8*i +: 8] = win_new[i];
            if ((srs_pkg::LEN_W'(i) < plen) && (win_new[i] != i_cfg.pat_bytes[8*i +: 8]))
                hit = 1'b0;
        end
        shv = wv >> 8;
    end

    always_comb begin
        o_job.data = wv;
        o_job.cnt = '0;
        o_job.last = i_req.in_last;
        n_fill = filled;
        for (int i = 0; i < PATTERN_MAX; i++)
            n_win[i] = win_new[i];
        if (plen == '0) begin
            o_job.data = VW'(i_req.in_byte);
            o_job.cnt = srs_pkg::LEN_W'(1);
            n_fill = '0;
        end else if (complete && hit) begin
            o_job.data = i_cfg.rep_bytes;
            o_job.cnt = rlen;
            n_fill = '0;
        end else if (complete) begin
            if (i_req.in_last) begin
                o_job.cnt = plen;
                n_fill = '0;
            end else begin
                o_job.cnt = srs_pkg::LEN_W'(1);
                n_fill = plen - 1'b1;
                for (int i = 0; i < PATTERN_MAX; i++)
                    n_win[i] = shv[8*i +: 8];
            end
        end else if (i_req.in_last) begin
            o_job.cnt = filled;
            n_fill = '0;
        end
    end

    assign o_push = accept && ((o_job.cnt != '0) || i_req.in_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_clr) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < PATTERN_MAX; i++)
                r_win[i] <= n_win[i];
        end
    end

endmodule

// ===== rtl/srs_queue.sv =====
// Short job queue between the front end and the output sequencer.
module srs_queue #(
    parameter int DEPTH = srs_pkg::JOB_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srs_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_nempty,
    output srs_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    srs_pkg::t_job    r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_nempty;
    assign o_job = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_job;
    end

endmodule

// ===== rtl/srs_back.sv =====
// Back end: walks each job one byte per cycle, while the output is not stalled, into the output register.
module srs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_nempty,
    input  srs_pkg::t_job    i_q_job,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output srs_pkg::t_out_req o_req
);

    srs_pkg::t_job     r_cur;
    srs_pkg::t_out_req r_out, n_out;
    logic [2:0]        r_idx, last_idx;
    logic              r_act, r_ovalid;
    logic              out_free, emit, done;

    assign last_idx = (r_cur.cnt == '0) ? 3'd0 : 3'(r_cur.cnt - 1'b1);
    assign out_free = !r_ovalid || !i_stall;
    assign emit = r_act && out_free;
    assign done = emit && (r_idx == last_idx);
    assign o_q_pop = i_q_nempty && (!r_act || done);

    always_comb begin
        n_out.byte_present = (r_cur.cnt != '0);
        n_out.out_byte = n_out.byte_present ? r_cur.data[8*r_idx +: 8] : '0;
        n_out.out_last = r_cur.last && (r_idx == last_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (out_free)
                r_ovalid <= emit;
            if (o_q_pop) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (done) begin
                r_act <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop)
            r_cur <= i_q_job;
        if (emit)
            r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_req = r_out;

endmodule

// ===== rtl/srs_checker.sv =====
// Port-level checks for the substring replacer, bound to the top level.
module srs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              pready,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input srs_pkg::t_out_req o_out_req
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled output request changed");

    a_empty_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_req.byte_present |->
            o_out_req.out_last && (o_out_req.out_byte == 8'h00))
        else $error("empty result is not a clean end mark");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind substring_replace_stream srs_checker u_srs_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .pready(pready),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_req(o_out_req)
);

// ===== sim/replace_checker.sv =====
// Checker for the substring replacer: predicts the output text and compares every result.
`timescale 1ns / 1ps

module replace_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [srs_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [srs_pkg::REG_W-1:0]   i_pwdata,
    input  logic                        i_pready,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  srs_pkg::t_in_req            i_in_req,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  srs_pkg::t_out_req           i_out_req,
    output int                          o_pending = 0,
    output int                          o_fail_count = 0,
    output int                          o_result_count = 0
);
    import srs_pkg::*;

    logic [REG_W-1:0] pat_bytes;
    logic [LEN_W-1:0] pat_len;
    logic [REG_W-1:0] rep_bytes;
    logic [LEN_W-1:0] rep_len;
    logic [BYTE_W-1:0] held [8];
    int unsigned held_cnt;
    t_out_req expected_text [$];

    function automatic t_out_req text_byte(input logic [BYTE_W-1:0] b);
        text_byte = '{out_byte: b, byte_present: 1'b1, out_last: 1'b0};
    endfunction

    task automatic predict_replace(input t_in_req req);
        t_out_req burst [16];
        int unsigned plen;
        int unsigned rlen;
        int unsigned n;
        int unsigned k;
        logic hit;
        plen = (pat_len > 4'd8) ? 8 : pat_len;
        rlen = (rep_len > 4'd8) ? 8 : rep_len;
        n = 0;
        if (plen == 0) begin
            held_cnt = 0;
            burst[n] = text_byte(req.in_byte);
            n++;
        end else begin
            if (held_cnt >= plen) begin
                held_cnt = 0;
            end
            held[held_cnt] = req.in_byte;
            held_cnt++;
            if (held_cnt == plen) begin
                hit = 1'b1;
                for (k = 0; k < plen; k++) begin
                    if (held[k] != pat_bytes[8*k +: 8]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    for (k = 0; k < rlen; k++) begin
                        burst[n] = text_byte(rep_bytes[8*k +: 8]);
                        n++;
                    end
                    held_cnt = 0;
                end else begin
                    burst[n] = text_byte(held[0]);
                    n++;
                    for (k = 0; k < 7; k++) begin
                        held[k] = held[k+1];
                    end
                    held[7] = '0;
                    held_cnt--;
                end
            end
        end
        if (req.in_last) begin
            for (k = 0; k < held_cnt; k++) begin
                burst[n] = text_byte(held[k]);
                n++;
            end
            held_cnt = 0;
            // nothing left to say: empty end mark
            if (n == 0) begin
                burst[0] = '{out_byte: '0, byte_present: 1'b0, out_last: 1'b0};
                n = 1;
            end
            burst[n-1].out_last = 1'b1;
        end
        for (k = 0; k < n; k++) begin
            expected_text.push_back(burst[k]);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            pat_bytes = '0;
            pat_len = '0;
            rep_bytes = '0;
            rep_len = '0;
            held_cnt = 0;
            for (int k = 0; k < 8; k++) begin
                held[k] = '0;
            end
            expected_text.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count <= o_result_count + 1;
                if (expected_text.size() == 0) begin
                    $error("unexpected result: out_byte %0h byte_present %0b out_last %0b",
                           i_out_req.out_byte, i_out_req.byte_present, i_out_req.out_last);
                    errs++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_out_req.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, i_out_req.out_byte);
                        errs++;
                    end
                    if (i_out_req.byte_present !== want.byte_present) begin
                        $error("byte_present: expected %0b, got %0b",
                               want.byte_present, i_out_req.byte_present);
                        errs++;
                    end
                    if (i_out_req.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, got %0b",
                               want.out_last, i_out_req.out_last);
                        errs++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_PAT_BYTES: begin
                        pat_bytes = i_pwdata;
                        held_cnt = 0;
                    end
                    REG_PAT_LEN: begin
                        pat_len = i_pwdata[LEN_W-1:0];
                        held_cnt = 0;
                    end
                    REG_REP_BYTES: rep_bytes = i_pwdata;
                    REG_REP_LEN: rep_len = i_pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_replace(i_in_req);
            end
        end
        if (errs != 0) begin
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_text.size();
    end

endmodule

// ===== sim/tb_substring_replace_stream.sv =====
// Testbench top for the substring replacer: clock, reset, register writes, text stimulus, verdict.
`timescale 1ns / 1ps

module tb_substring_replace_stream;
    import srs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 80;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 36;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [REG_W-1:0] pwdata = '0;
    logic [REG_W-1:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_req i_in_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_req o_out_req;

    int pending;
    int fails;
    int results;
    int cycle_count = 0;
    int sent = 0;
    int texts = 0;
    int settings = 0;
    bit long_hold = 1'b0;
    bit calm = 1'b0;
    logic [REG_W-1:0] cur_pat = '0;
    int cur_plen = 0;

    substring_replace_stream i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_req  (o_out_req)
    );

    replace_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_req      (i_in_req),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_req     (o_out_req),
        .o_pending     (pending),
        .o_fail_count  (fails),
        .o_result_count(results)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding", pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // output back-pressure: random bursts, one long hold-off on request
    initial begin : out_stall_gen
        int span;
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                span = $urandom_range(1, 5);
                repeat (span) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                span = $urandom_range(1, 8);
                repeat (span) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [REG_W-1:0] pat, input logic [LEN_W-1:0] plen,
                                  input logic [REG_W-1:0] rep, input logic [LEN_W-1:0] rlen);
        write_reg(REG_PAT_BYTES, pat);
        write_reg(REG_PAT_LEN, REG_W'(plen));
        write_reg(REG_REP_BYTES, rep);
        write_reg(REG_REP_LEN, REG_W'(rlen));
        cur_pat = pat;
        cur_plen = (plen > 4'd8) ? 8 : plen;
        settings++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_in_req req;
        logic taken;
        req.in_byte = b;
        req.in_last = last;
        i_in_valid <= 1'b1;
        i_in_req <= req;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        sent++;
        if (last) begin
            texts++;
        end
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic idle_until_drained;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pattern_byte(input int k);
        logic [BYTE_W-1:0] b;
        b = cur_pat[8*k +: 8];
        pattern_byte = (b == '0) ? 8'h01 : b;
    endfunction

    initial begin : stimulus
        int phase;
        int phase_sent;
        int parts;
        int pick;
        int cut;
        int plen_w;
        int rlen_w;
        logic [REG_W-1:0] pat_w;
        logic leave_open;
        logic [BYTE_W-1:0] text [$];

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through straight out of reset, zero byte included
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        idle_until_drained();

        write_settings(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("x", 1'b1);
        send_byte("a", 1'b1);
        send_byte("b", 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b1);
        idle_until_drained();

        // empty replacement on the last byte gives the end mark
        write_reg(REG_REP_LEN, REG_W'(0));
        send_byte("a", 1'b0);
        send_byte("b", 1'b1);
        // pattern rewrite mid-text drops the held byte
        send_byte("a", 1'b0);
        idle_until_drained();
        write_reg(REG_PAT_BYTES, 64'h6261);
        send_byte("b", 1'b1);
        idle_until_drained();

        // lengths above the maximum saturate
        write_settings('1, 4'd15, 64'h0807060504030201, 4'd15);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        idle_until_drained();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: plen_w = 1;
                2: plen_w = 0;
                4: plen_w = 8;
                5: plen_w = $urandom_range(9, 15);
                default: plen_w = $urandom_range(1, 8);
            endcase
            case (phase)
                3: rlen_w = 0;
                6: rlen_w = 15;
                default: rlen_w = $urandom_range(0, 8);
            endcase
            for (int k = 0; k < 8; k++) begin
                pat_w[8*k +: 8] = 8'($urandom_range(8'h61, 8'h63));
            end
            if (phase == 6) begin
                pat_w = {$urandom, $urandom};
            end
            write_settings(pat_w, plen_w[LEN_W-1:0], {$urandom, $urandom}, rlen_w[LEN_W-1:0]);
            if (phase == 1) begin
                long_hold = 1'b1;
            end
            if (phase == NUM_PHASES - 1) begin
                calm = 1'b1;
            end
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                text.delete();
                parts = $urandom_range(1, 8);
                repeat (parts) begin
                    pick = $urandom_range(0, 9);
                    if (cur_plen > 0 && pick < 4) begin
                        for (int k = 0; k < cur_plen; k++) begin
                            text.push_back(pattern_byte(k));
                        end
                    end else if (cur_plen > 1 && pick < 6) begin
                        cut = $urandom_range(1, cur_plen - 1);
                        for (int k = 0; k < cut; k++) begin
                            text.push_back(pattern_byte(k));
                        end
                    end else if (cur_plen > 0 && pick < 8) begin
                        text.push_back(pattern_byte($urandom_range(0, cur_plen - 1)));
                    end else begin
                        text.push_back(8'($urandom_range(1, 255)));
                    end
                end
                // now and then a phase ends mid-text so the next pattern write drops it
                leave_open = (phase_sent + text.size() >= PHASE_ITEMS)
                             && ($urandom_range(0, 1) == 0);
                foreach (text[i]) begin
                    send_byte(text[i], (i == text.size() - 1) && !leave_open);
                end
                phase_sent += text.size();
            end
            idle_until_drained();
        end

        $display("Covered %0d requests in %0d texts over %0d register settings, %0d results.",
                 sent, texts, settings, results);
        $display("Included saturated lengths, empty pattern and replacement, mid-text rewrite.");
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srs_pkg.sv
rtl/srs_front.sv
rtl/srs_queue.sv
rtl/srs_back.sv
rtl/substring_replace_stream.sv
rtl/srs_checker.sv
sim/replace_checker.sv
sim/tb_substring_replace_stream.sv
